[rtl/core/ordered_record_list_core_assert.svh]
// assertion macros for the ordered record list core
// no dependencies; taken in by `include from the modules that assert
`ifndef ORDERED_RECORD_LIST_CORE_ASSERT_SVH
`define ORDERED_RECORD_LIST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ORL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ordered record list assertion failed");
`define ORL_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ordered record list reset assertion failed");
`else
`define ORL_ASSERT(label, clk, rst_n, prop)
`define ORL_ASSERT_NR(label, clk, prop)
`endif

`endif

[rtl/core/orl_pkg.sv]
// types and constants for the ordered record list core
// no dependencies
package orl_pkg;

    localparam int ID_W   = 16;
    localparam int PRI_W  = 16;
    localparam int WORD_W = ID_W + PRI_W;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_SEARCH     = 3'd2,
        OP_READ       = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_HEAD,
        S_SEARCH,
        S_READ,
        S_SHIFT_DOWN,
        S_DONE
    } t_state;

endpackage

[rtl/core/ordered_record_list_core.sv]
// ordered record list core: bounded list of id/priority records in one memory
// depends on orl_pkg and ordered_record_list_core_assert.svh
//
// One operation is taken per input word and gives one result word. Records sit in a
// single memory with one write and one registered read port, so the sequencer moves
// one entry per cycle: push front shifts the entries up from the tail and then writes
// the head, search scans from the head until a hit or the end of the list, and remove
// reads the entry and shifts the later entries down. A result waits in the done state
// until the output register is free to take it. The input is ready only while the
// sequencer is idle.
module ordered_record_list_core #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_item_id,
    input  logic [15:0] i_item_priority,
    input  logic [5:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_found_position,
    output logic [15:0] o_out_id,
    output logic [15:0] o_out_priority,
    output logic [5:0]  o_entry_count
);

    `include "ordered_record_list_core_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int PW = (CW > 6) ? CW : 6;
    localparam int FW = (AW > 5) ? AW : 5;
    localparam int XW = (CW > 6) ? CW : 6;
    localparam int WW = orl_pkg::WORD_W;

    orl_pkg::t_state  r_state, n_state;
    orl_pkg::t_op     r_op, n_op;
    orl_pkg::t_status r_status, n_status;
    logic [15:0]      r_id, n_id;
    logic [15:0]      r_pri, n_pri;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_found, n_found;
    logic [15:0]      r_oid, n_oid;
    logic [15:0]      r_opri, n_opri;

    logic             r_out_valid, n_out_valid;
    orl_pkg::t_status r_out_status, n_out_status;
    logic [4:0]       r_out_found, n_out_found;
    logic [15:0]      r_out_id, n_out_id;
    logic [15:0]      r_out_pri, n_out_pri;
    logic [5:0]       r_out_count, n_out_count;

    logic [WW-1:0]    r_mem [DEPTH];
    logic [WW-1:0]    r_rd_data;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [WW-1:0]    mem_wdata;

    logic             accept;
    logic             out_free;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic             hit;
    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    cnt_pos;
    logic [AW-1:0]    pos_idx;
    logic [CW-1:0]    cnt_m1;
    logic [IW-1:0]    cnt_i;
    logic [IW-1:0]    idx_p1;
    logic [IW-1:0]    idx_p2;
    logic [FW-1:0]    found_ext;
    logic [XW-1:0]    count_ext;
    orl_pkg::t_op     in_op;

    assign o_in_ready = (r_state == orl_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_op      = orl_pkg::t_op'(i_operation);
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign pos_ext    = PW'(i_position);
    assign cnt_pos    = PW'(r_count);
    assign pos_bad    = (pos_ext >= cnt_pos);
    assign pos_idx    = pos_ext[AW-1:0];
    assign cnt_m1     = r_count - 1'b1;
    assign cnt_i      = IW'(r_count);
    assign idx_p1     = IW'(r_idx) + IW'(1);
    assign idx_p2     = IW'(r_idx) + IW'(2);
    assign hit        = (r_rd_data[WW-1:orl_pkg::PRI_W] == r_id);
    assign found_ext  = FW'(r_found);
    assign count_ext  = XW'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            orl_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (in_op) inside
                        orl_pkg::OP_PUSH_FRONT: begin
                            n_state = (full || empty) ? orl_pkg::S_DONE
                                                      : orl_pkg::S_SHIFT_UP;
                        end
                        orl_pkg::OP_SEARCH: begin
                            n_state = empty ? orl_pkg::S_DONE : orl_pkg::S_SEARCH;
                        end
                        orl_pkg::OP_READ, orl_pkg::OP_REMOVE: begin
                            n_state = pos_bad ? orl_pkg::S_DONE : orl_pkg::S_READ;
                        end
                        default: n_state = orl_pkg::S_DONE;
                    endcase
                end
            end
            orl_pkg::S_SHIFT_UP: begin
                if (r_idx == '0) n_state = orl_pkg::S_HEAD;
            end
            orl_pkg::S_HEAD: n_state = orl_pkg::S_DONE;
            orl_pkg::S_SEARCH: begin
                if (hit || idx_p1 == cnt_i) n_state = orl_pkg::S_DONE;
            end
            orl_pkg::S_READ: begin
                if (r_op == orl_pkg::OP_REMOVE && idx_p1 != cnt_i) begin
                    n_state = orl_pkg::S_SHIFT_DOWN;
                end else begin
                    n_state = orl_pkg::S_DONE;
                end
            end
            orl_pkg::S_SHIFT_DOWN: begin
                if (idx_p2 == cnt_i) n_state = orl_pkg::S_DONE;
            end
            orl_pkg::S_DONE: begin
                if (out_free) n_state = orl_pkg::S_IDLE;
            end
            default: n_state = orl_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op         = r_op;
        n_status     = r_status;
        n_id         = r_id;
        n_pri        = r_pri;
        n_idx        = r_idx;
        n_count      = r_count;
        n_found      = r_found;
        n_oid        = r_oid;
        n_opri       = r_opri;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_id     = r_out_id;
        n_out_pri    = r_out_pri;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = {r_id, r_pri};
        mem_raddr    = r_idx;
        unique case (r_state)
            orl_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = in_op;
                    n_id     = i_item_id;
                    n_pri    = i_item_priority;
                    n_status = orl_pkg::ST_OK;
                    n_found  = '0;
                    n_oid    = '0;
                    n_opri   = '0;
                    unique case (in_op) inside
                        orl_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = orl_pkg::ST_FULL;
                            end else if (empty) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = {i_item_id, i_item_priority};
                                n_count   = r_count + 1'b1;
                            end else begin
                                mem_raddr = cnt_m1[AW-1:0];
                                n_idx     = cnt_m1[AW-1:0];
                            end
                        end
                        orl_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = orl_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = {i_item_id, i_item_priority};
                                n_count   = r_count + 1'b1;
                            end
                        end
                        orl_pkg::OP_SEARCH: begin
                            if (empty) begin
                                n_status = orl_pkg::ST_NOT_FOUND;
                            end else begin
                                mem_raddr = '0;
                                n_idx     = '0;
                            end
                        end
                        orl_pkg::OP_READ, orl_pkg::OP_REMOVE: begin
                            if (pos_bad) begin
                                n_status = orl_pkg::ST_BAD_POS;
                            end else begin
                                mem_raddr = pos_idx;
                                n_idx     = pos_idx;
                            end
                        end
                        orl_pkg::OP_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            orl_pkg::S_SHIFT_UP: begin
                mem_we    = 1'b1;
                mem_waddr = idx_p1[AW-1:0];
                mem_wdata = r_rd_data;
                mem_raddr = r_idx - 1'b1;
                n_idx     = r_idx - 1'b1;
            end
            orl_pkg::S_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {r_id, r_pri};
                n_count   = r_count + 1'b1;
            end
            orl_pkg::S_SEARCH: begin
                if (hit) begin
                    n_found = r_idx;
                end else if (idx_p1 == cnt_i) begin
                    n_status = orl_pkg::ST_NOT_FOUND;
                end else begin
                    n_idx     = idx_p1[AW-1:0];
                    mem_raddr = idx_p1[AW-1:0];
                end
            end
            orl_pkg::S_READ: begin
                n_oid  = r_rd_data[WW-1:orl_pkg::PRI_W];
                n_opri = r_rd_data[orl_pkg::PRI_W-1:0];
                if (r_op == orl_pkg::OP_REMOVE) begin
                    if (idx_p1 == cnt_i) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        mem_raddr = idx_p1[AW-1:0];
                    end
                end
            end
            orl_pkg::S_SHIFT_DOWN: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd_data;
                n_idx     = idx_p1[AW-1:0];
                if (idx_p2 == cnt_i) begin
                    n_count = r_count - 1'b1;
                end else begin
                    mem_raddr = idx_p2[AW-1:0];
                end
            end
            orl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = found_ext[4:0];
                    n_out_id     = r_oid;
                    n_out_pri    = r_opri;
                    n_out_count  = count_ext[5:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_id         <= n_id;
        r_pri        <= n_pri;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_oid        <= n_oid;
        r_opri       <= n_opri;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_id     <= n_out_id;
        r_out_pri    <= n_out_pri;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_out_id         = r_out_id;
    assign o_out_priority   = r_out_pri;
    assign o_entry_count    = r_out_count;

    `ORL_ASSERT_NR(a_reset_idle, i_clk,
        (!i_rst_n) |=> (r_state == orl_pkg::S_IDLE && !r_out_valid))
    `ORL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `ORL_ASSERT(a_accept_busy, i_clk, i_rst_n, accept |=> (r_state != orl_pkg::S_IDLE))
    `ORL_ASSERT(a_load_from_done, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == orl_pkg::S_DONE))
    `ORL_ASSERT(a_shift_up_count, i_clk, i_rst_n,
        (r_state == orl_pkg::S_SHIFT_UP) |=> $stable(r_count))

endmodule
